// ===== rtl/dvsf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the ADPCM voice sample fetch block.
// No dependencies; imported by every other file but dvsf_ram.
package dvsf_pkg;

	localparam int STORE_BYTES = 4096;
	localparam int STORE_AW    = $clog2(STORE_BYTES);
	localparam int COEF_COUNT  = 16;
	localparam int COEF_AW     = $clog2(COEF_COUNT);
	localparam int ADDR_W      = 32;
	localparam int SIZE_W      = 13;
	localparam int CTX_W       = 40;
	localparam int CFG_IDX_W   = 3;
	localparam int SMP_W       = 16;

	typedef enum logic [1:0] {
		REQ_STORE  = 2'd0,
		REQ_COEF   = 2'd1,
		REQ_START  = 2'd2,
		REQ_DECODE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		FMT_ADPCM = 2'd0,
		FMT_PCM16 = 2'd1,
		FMT_PCM8  = 2'd2,
		FMT_NONE  = 2'd3
	} fmt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FORMAT    = 3'd0,
		CFG_START     = 3'd1,
		CFG_END       = 3'd2,
		CFG_LOOP_ADDR = 3'd3,
		CFG_LOOP_EN   = 3'd4,
		CFG_LOOP_CTX  = 3'd5,
		CFG_INIT_CTX  = 3'd6,
		CFG_MEM_SIZE  = 3'd7
	} cfg_reg_t;

	// Operands of one ADPCM predictor evaluation.
	typedef struct packed {
		logic [3:0]       nibble;
		logic [3:0]       scale;
		logic [SMP_W-1:0] coef0;
		logic [SMP_W-1:0] coef1;
		logic [SMP_W-1:0] hist1;
		logic [SMP_W-1:0] hist2;
	} pred_in_t;

endpackage

// ===== rtl/dvsf_ram.sv =====
`timescale 1ns / 1ps
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module dvsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re_a,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic             re_b,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/dvsf_pred.sv =====
`timescale 1ns / 1ps
// ADPCM two-tap predictor: registered products, then round, shift and saturate.
// Depends on dvsf_pkg for pred_in_t and widths.
module dvsf_pred import dvsf_pkg::*; (
	input  logic             clk,
	input  logic             go,
	input  pred_in_t         pin,
	output logic [SMP_W-1:0] sample
);

	logic signed [19:0] nib_ext;
	logic signed [19:0] nterm_d;
	logic signed [31:0] prod0_d;
	logic signed [31:0] prod1_d;
	logic signed [19:0] nterm_s3;
	logic signed [31:0] prod0_s3;
	logic signed [31:0] prod1_s3;
	logic signed [33:0] sum;
	logic signed [22:0] quot;

	// Nibble times 2^scale; the 2^11 factor is applied after the register.
	assign nib_ext = $signed({{16{pin.nibble[3]}}, pin.nibble});
	assign nterm_d = nib_ext <<< pin.scale;
	assign prod0_d = $signed(pin.coef0) * $signed(pin.hist1);
	assign prod1_d = $signed(pin.coef1) * $signed(pin.hist2);

	always_ff @(posedge clk) begin
		if (go) begin
			nterm_s3 <= nterm_d;
			prod0_s3 <= prod0_d;
			prod1_s3 <= prod1_d;
		end
	end

	// Round to nearest, floor on the arithmetic shift, clamp to 16 bits.
	assign sum = (34'(nterm_s3) <<< 11) + 34'(prod0_s3) + 34'(prod1_s3) + 34'sd1024;
	assign quot = 23'(sum >>> 11);

	always_comb begin
		if (quot > 23'sd32767) begin
			sample = 16'h7FFF;
		end else if (quot < -23'sd32768) begin
			sample = 16'h8000;
		end else begin
			sample = quot[SMP_W-1:0];
		end
	end

endmodule

// ===== rtl/dsp_adpcm_voice_sample_fetch.sv =====
`timescale 1ns / 1ps
// Top level of the single-voice ADPCM / PCM sample fetch block.
// Depends on dvsf_pkg, dvsf_ram (sample store, coefficients) and dvsf_pred.
//
// One audio voice that plays samples out of a 4096-byte local store. Every input
// word gives exactly one result word. Store-write and coefficient-write words load
// the store and the sixteen predictor coefficients (they are written at the edge
// the word is taken); a start word loads the address and the decoder context from
// the configuration registers and turns the voice on; a decode word yields one
// sample in ADPCM (16-nibble frames with a header byte, two-tap predictor, round,
// shift by 11, saturate), big-endian PCM16 or PCM8 scaled by 256. At the end
// address the voice loops and reloads the loop context, or stops. The block takes
// a word only while stage 1 is empty: the store read data is back in the cycle
// after a word is taken, and the next address, predictor/scale byte and active
// flag are known only once that read data is back. A result is held in an output
// register, so a new word is taken while a result waits. The store and coefficients
// need no clearing after reset; configuration is written through the cfg port
// (always ready) by the user while the block is idle; the block does not check it.
module dsp_adpcm_voice_sample_fetch import dvsf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input words
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [11:0]          write_index,
	input  logic [15:0]          write_data,
	// result words
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SMP_W-1:0]     sample_out,
	output logic                 ok,
	output logic                 voice_active,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CTX_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		HIST_KEEP,
		HIST_SAMPLE,
		HIST_LOOP,
		HIST_INIT
	} hist_op_t;

	// configuration registers
	fmt_t              format_q;
	logic [ADDR_W-1:0] start_addr_q;
	logic [ADDR_W-1:0] end_addr_q;
	logic [ADDR_W-1:0] loop_addr_q;
	logic              loop_en_q;
	logic [CTX_W-1:0]  loop_ctx_q;
	logic [CTX_W-1:0]  init_ctx_q;
	logic [SIZE_W-1:0] mem_size_q;

	// voice state
	logic [ADDR_W-1:0] cur_q;
	logic [7:0]        ps_q;
	logic [SMP_W-1:0]  hist1_q;
	logic [SMP_W-1:0]  hist2_q;
	logic              active_q;

	// handshake and pipeline control
	logic accept;
	logic go_s1;
	logic go_s2;
	logic go_s3;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic out_valid_q;

	// stage 1: store read data is back
	req_t              req_s1;
	logic              idx_ok_s1;

	// stage 2: coefficient read data is back
	logic              ok_s2;
	logic              active_s2;
	logic [SMP_W-1:0]  smp_s2;
	logic              use_pred_s2;
	hist_op_t          hist_s2;
	logic [3:0]        nib_s2;
	logic [3:0]        scale_s2;

	// stage 3: products registered
	logic              ok_s3;
	logic              active_s3;
	logic [SMP_W-1:0]  smp_s3;
	logic              use_pred_s3;
	hist_op_t          hist_s3;

	// output register
	logic [SMP_W-1:0]  sample_q;
	logic              ok_q;
	logic              active_out_q;

	// address decode
	req_t              in_req;
	logic              store_idx_ok;
	logic              coef_idx_ok;
	logic [SIZE_W-1:0] size_eff;
	logic              is_frame;
	logic [ADDR_W-1:0] pos2;
	logic              hdr_oob;
	logic              dat_oob;
	logic              bad_pos;
	logic              pcm16_oob;
	logic              pcm8_oob;
	logic [STORE_AW-1:0] store_ra_a;
	logic [STORE_AW-1:0] store_ra_b;
	logic [7:0]        store_rd_a;
	logic [7:0]        store_rd_b;

	// stage 1 results
	logic              hdr_load;
	logic [7:0]        ps_fetch;
	logic              fetch_fail;
	logic [SMP_W-1:0]  direct_smp;
	logic [ADDR_W-1:0] nx_cur;
	logic [7:0]        nx_ps;
	logic              nx_active;
	logic              r_ok;
	logic [SMP_W-1:0]  r_smp;
	logic              r_use_pred;
	hist_op_t          r_hist;
	logic [3:0]        r_nib;
	logic [COEF_AW-1:0] coef_ra0;
	logic [COEF_AW-1:0] coef_ra1;
	logic [SMP_W-1:0]  coef_rd0;
	logic [SMP_W-1:0]  coef_rd1;

	pred_in_t          pin;
	logic [SMP_W-1:0]  pred_smp;
	logic [SMP_W-1:0]  final_smp;

	// Take a word only with stage 1 empty: the voice state it reads is settled then.
	assign in_stall  = valid_s1;
	assign accept    = in_valid && !in_stall;
	assign go_s3     = valid_s3 && (!out_valid_q || !out_stall);
	// Hold stage 2 until stage 3 has drained, so history is committed before use.
	assign go_s2     = valid_s2 && !valid_s3;
	assign go_s1     = valid_s1 && (!valid_s2 || go_s2);
	assign cfg_ready = 1'b1;

	assign out_valid    = out_valid_q;
	assign sample_out   = sample_q;
	assign ok           = ok_q;
	assign voice_active = active_out_q;

	assign in_req       = req_t'(req_type);
	assign store_idx_ok = ADDR_W'(write_index) < ADDR_W'(STORE_BYTES);
	assign coef_idx_ok  = write_index < 12'(COEF_COUNT);

	// Positions come from the current address, which only stage 1 updates,
	// so the same values serve the read issue and the stage 1 checks.
	assign size_eff  = (mem_size_q > SIZE_W'(STORE_BYTES)) ? SIZE_W'(STORE_BYTES) : mem_size_q;
	assign is_frame  = (cur_q[3:0] == 4'd0);
	assign pos2      = (format_q == FMT_ADPCM && is_frame) ? cur_q + ADDR_W'(2) : cur_q;
	assign hdr_oob   = (cur_q >> 1) >= ADDR_W'(size_eff);
	assign dat_oob   = (pos2 >> 1) >= ADDR_W'(size_eff);
	assign bad_pos   = (pos2[3:0] == 4'd1);
	assign pcm16_oob = {cur_q, 1'b1} >= (ADDR_W + 1)'(size_eff);
	assign pcm8_oob  = cur_q >= ADDR_W'(size_eff);

	always_comb begin
		unique case (format_q)
			FMT_ADPCM: begin
				store_ra_a = STORE_AW'(cur_q >> 1);
				store_ra_b = STORE_AW'(pos2 >> 1);
			end
			FMT_PCM16: begin
				store_ra_a = STORE_AW'({cur_q, 1'b0});
				store_ra_b = STORE_AW'({cur_q, 1'b1});
			end
			FMT_PCM8, FMT_NONE: begin
				store_ra_a = STORE_AW'(cur_q);
				store_ra_b = STORE_AW'(cur_q);
			end
		endcase
	end

	dvsf_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk    (clk),
		.we     (accept && in_req == REQ_STORE && store_idx_ok),
		.waddr  (STORE_AW'(write_index)),
		.wdata  (write_data[7:0]),
		.re_a   (accept),
		.raddr_a(store_ra_a),
		.rdata_a(store_rd_a),
		.re_b   (accept),
		.raddr_b(store_ra_b),
		.rdata_b(store_rd_b)
	);

	// Stage 1: header, range checks, next address and context.
	assign hdr_load = (format_q == FMT_ADPCM) && is_frame && !hdr_oob;
	assign ps_fetch = hdr_load ? store_rd_a : ps_q;
	assign r_nib    = pos2[0] ? store_rd_b[3:0] : store_rd_b[7:4];
	assign coef_ra0 = {ps_fetch[6:4], 1'b0};
	assign coef_ra1 = {ps_fetch[6:4], 1'b1};

	always_comb begin
		unique case (format_q)
			FMT_ADPCM: begin
				fetch_fail = hdr_oob || bad_pos || dat_oob || ps_fetch[7];
				direct_smp = '0;
			end
			FMT_PCM16: begin
				fetch_fail = pcm16_oob;
				direct_smp = {store_rd_a, store_rd_b};
			end
			FMT_PCM8: begin
				fetch_fail = pcm8_oob;
				direct_smp = {store_rd_a, 8'h00};
			end
			FMT_NONE: begin
				fetch_fail = 1'b1;
				direct_smp = '0;
			end
		endcase
	end

	always_comb begin
		nx_cur     = cur_q;
		nx_ps      = ps_q;
		nx_active  = active_q;
		r_ok       = 1'b1;
		r_smp      = '0;
		r_use_pred = 1'b0;
		r_hist     = HIST_KEEP;
		unique case (req_s1)
			REQ_STORE, REQ_COEF: begin
				r_ok = idx_ok_s1;
			end
			REQ_START: begin
				nx_cur    = start_addr_q;
				nx_ps     = init_ctx_q[39:32];
				nx_active = 1'b1;
				r_hist    = HIST_INIT;
			end
			REQ_DECODE: begin
				if (active_q) begin
					// a header just fetched stays even when the fetch fails
					nx_ps = ps_fetch;
					r_ok  = !fetch_fail;
					if (!fetch_fail) begin
						r_smp = direct_smp;
						if (format_q == FMT_ADPCM) begin
							r_use_pred = 1'b1;
							r_hist     = HIST_SAMPLE;
						end
						if (pos2 == end_addr_q) begin
							if (loop_en_q) begin
								nx_cur = loop_addr_q;
								nx_ps  = loop_ctx_q[39:32];
								r_hist = HIST_LOOP;
							end else begin
								nx_cur    = pos2;
								nx_active = 1'b0;
							end
						end else begin
							nx_cur = pos2 + ADDR_W'(1);
						end
					end
				end
			end
		endcase
	end

	dvsf_ram #(
		.WIDTH(SMP_W),
		.DEPTH(COEF_COUNT)
	) u_coef (
		.clk    (clk),
		.we     (accept && in_req == REQ_COEF && coef_idx_ok),
		.waddr  (COEF_AW'(write_index)),
		.wdata  (write_data),
		.re_a   (go_s1),
		.raddr_a(coef_ra0),
		.rdata_a(coef_rd0),
		.re_b   (go_s1),
		.raddr_b(coef_ra1),
		.rdata_b(coef_rd1)
	);

	// Stage 2 to 3: predictor products with the committed history.
	assign pin.nibble = nib_s2;
	assign pin.scale  = scale_s2;
	assign pin.coef0  = coef_rd0;
	assign pin.coef1  = coef_rd1;
	assign pin.hist1  = hist1_q;
	assign pin.hist2  = hist2_q;

	dvsf_pred u_pred (
		.clk   (clk),
		.go    (go_s2),
		.pin   (pin),
		.sample(pred_smp)
	);

	assign final_smp = use_pred_s3 ? pred_smp : smp_s3;

	// Control state, voice state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			out_valid_q  <= 1'b0;
			cur_q        <= '0;
			ps_q         <= '0;
			hist1_q      <= '0;
			hist2_q      <= '0;
			active_q     <= 1'b0;
			format_q     <= FMT_ADPCM;
			start_addr_q <= '0;
			end_addr_q   <= '0;
			loop_addr_q  <= '0;
			loop_en_q    <= 1'b0;
			loop_ctx_q   <= '0;
			init_ctx_q   <= '0;
			mem_size_q   <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (go_s1) begin
				valid_s2 <= 1'b1;
			end else if (go_s2) begin
				valid_s2 <= 1'b0;
			end
			if (go_s2) begin
				valid_s3 <= 1'b1;
			end else if (go_s3) begin
				valid_s3 <= 1'b0;
			end
			if (go_s3) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// advance address, scale byte and active flag as a word leaves stage 1
			if (go_s1) begin
				cur_q    <= nx_cur;
				ps_q     <= nx_ps;
				active_q <= nx_active;
			end

			// commit history in word order as a word leaves stage 3
			if (go_s3) begin
				unique case (hist_s3)
					HIST_KEEP: begin
					end
					HIST_SAMPLE: begin
						hist2_q <= hist1_q;
						hist1_q <= final_smp;
					end
					HIST_LOOP: begin
						hist1_q <= loop_ctx_q[31:16];
						hist2_q <= loop_ctx_q[15:0];
					end
					HIST_INIT: begin
						hist1_q <= init_ctx_q[31:16];
						hist2_q <= init_ctx_q[15:0];
					end
				endcase
			end

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_FORMAT:    format_q     <= fmt_t'(cfg_data[1:0]);
					CFG_START:     start_addr_q <= cfg_data[ADDR_W-1:0];
					CFG_END:       end_addr_q   <= cfg_data[ADDR_W-1:0];
					CFG_LOOP_ADDR: loop_addr_q  <= cfg_data[ADDR_W-1:0];
					CFG_LOOP_EN:   loop_en_q    <= cfg_data[0];
					CFG_LOOP_CTX:  loop_ctx_q   <= cfg_data;
					CFG_INIT_CTX:  init_ctx_q   <= cfg_data;
					CFG_MEM_SIZE:  mem_size_q   <= cfg_data[SIZE_W-1:0];
				endcase
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1    <= in_req;
			idx_ok_s1 <= (in_req == REQ_STORE) ? store_idx_ok : coef_idx_ok;
		end
		if (go_s1) begin
			ok_s2       <= r_ok;
			active_s2   <= nx_active;
			smp_s2      <= r_smp;
			use_pred_s2 <= r_use_pred;
			hist_s2     <= r_hist;
			nib_s2      <= r_nib;
			scale_s2    <= ps_fetch[3:0];
		end
		if (go_s2) begin
			ok_s3       <= ok_s2;
			active_s3   <= active_s2;
			smp_s3      <= smp_s2;
			use_pred_s3 <= use_pred_s2;
			hist_s3     <= hist_s2;
		end
		if (go_s3) begin
			sample_q     <= final_smp;
			ok_q         <= ok_s3;
			active_out_q <= active_s3;
		end
	end

endmodule

// ===== sim/dvsf_voice_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the ADPCM voice sample fetch block: models the voice, compares result words.
// Depends on dvsf_pkg for the request, format and register codes.
module dvsf_voice_checker import dvsf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [11:0]          write_index,
	input  logic [15:0]          write_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [SMP_W-1:0]     sample_out,
	input  logic                 ok,
	input  logic                 voice_active,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CTX_W-1:0]     cfg_data,
	output logic                 busy,
	output int                   fail_count
);

	typedef struct packed {
		logic [SMP_W-1:0] sample;
		logic             ok;
		logic             active;
	} voice_word_t;

	voice_word_t due_words[$];
	int          mismatches;

	// voice state
	logic [7:0]       store_mem [STORE_BYTES];
	logic [SMP_W-1:0] coef_mem [COEF_COUNT];
	logic [ADDR_W-1:0] play_addr;
	logic [7:0]       ps;
	logic [SMP_W-1:0] hist1, hist2;
	logic             active_q;

	// register copies
	fmt_t              fmt;
	logic [ADDR_W-1:0] start_addr, end_addr, loop_addr;
	logic              loop_en;
	logic [CTX_W-1:0]  loop_ctx, init_ctx;
	logic [SIZE_W-1:0] mem_size;

	function automatic void set_context(input logic [CTX_W-1:0] c);
		ps    = c[39:32];
		hist1 = c[31:16];
		hist2 = c[15:0];
	endfunction

	function automatic logic fetch_sample(output logic [SMP_W-1:0] smp);
		logic [ADDR_W-1:0] lim;
		logic [ADDR_W-1:0] pos;
		logic [ADDR_W+1:0] b2;
		logic [3:0]        pred;
		logic [3:0]        nib;
		longint            acc;
		lim = (mem_size > STORE_BYTES) ? STORE_BYTES : mem_size;
		pos = play_addr;
		smp = '0;
		case (fmt)
			FMT_ADPCM: begin
				// a frame header loads the scale byte and keeps it even if this word fails
				if (pos[3:0] == 4'd0) begin
					if ((pos >> 1) >= lim)
						return 1'b0;
					ps  = store_mem[pos[12:1]];
					pos = pos + 2;
				end
				if (pos[3:0] == 4'd1 || (pos >> 1) >= lim)
					return 1'b0;
				pred = ps[7:4];
				if (pred >= 8)
					return 1'b0;
				nib = pos[0] ? store_mem[pos[12:1]][3:0] : store_mem[pos[12:1]][7:4];
				acc = longint'($signed(nib)) * (longint'(1) << ps[3:0]) * 2048;
				acc += longint'($signed(coef_mem[{pred[2:0], 1'b0}])) * longint'($signed(hist1));
				acc += longint'($signed(coef_mem[{pred[2:0], 1'b1}])) * longint'($signed(hist2));
				acc = (acc + 1024) >>> 11;
				if (acc > 32767)
					acc = 32767;
				else if (acc < -32768)
					acc = -32768;
				smp   = acc[SMP_W-1:0];
				hist2 = hist1;
				hist1 = smp;
			end
			FMT_PCM16: begin
				b2 = {1'b0, pos, 1'b0};
				if (b2 + 1 >= lim)
					return 1'b0;
				smp = {store_mem[b2[11:0]], store_mem[b2[11:0] + 12'd1]};
			end
			FMT_PCM8: begin
				if (pos >= lim)
					return 1'b0;
				smp = {store_mem[pos[11:0]], 8'h00};
			end
			default: return 1'b0;
		endcase
		// loop or stop at the end address, else advance
		if (pos == end_addr) begin
			if (loop_en) begin
				pos = loop_addr;
				set_context(loop_ctx);
			end else begin
				active_q = 1'b0;
			end
		end else begin
			pos = pos + 1;
		end
		play_addr = pos;
		return 1'b1;
	endfunction

	function automatic voice_word_t voice_step(input req_t req, input logic [11:0] idx,
			input logic [15:0] data);
		voice_word_t      w;
		logic [SMP_W-1:0] smp;
		w.sample = '0;
		w.ok     = 1'b1;
		case (req)
			REQ_STORE: store_mem[idx] = data[7:0];
			REQ_COEF: begin
				if (idx < COEF_COUNT)
					coef_mem[idx[COEF_AW-1:0]] = data;
				else
					w.ok = 1'b0;
			end
			REQ_START: begin
				play_addr = start_addr;
				set_context(init_ctx);
				active_q = 1'b1;
			end
			default: begin
				if (active_q) begin
					w.ok     = fetch_sample(smp);
					w.sample = w.ok ? smp : '0;
				end
			end
		endcase
		w.active = active_q;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		voice_word_t want;
		if (!arst_n) begin
			due_words.delete();
			mismatches = 0;
			play_addr  = '0;
			ps         = '0;
			hist1      = '0;
			hist2      = '0;
			active_q   = 1'b0;
			fmt        = FMT_ADPCM;
			start_addr = '0;
			end_addr   = '0;
			loop_addr  = '0;
			loop_en    = 1'b0;
			loop_ctx   = '0;
			init_ctx   = '0;
			mem_size   = '0;
			busy       <= 1'b0;
			fail_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					$error("result word with nothing outstanding");
					mismatches++;
				end else begin
					want = due_words.pop_front();
					if (sample_out !== want.sample) begin
						$error("sample_out: expected %0d, got %0d",
							$signed(want.sample), $signed(sample_out));
						mismatches++;
					end
					if (ok !== want.ok) begin
						$error("ok: expected %0b, got %0b", want.ok, ok);
						mismatches++;
					end
					if (voice_active !== want.active) begin
						$error("voice_active: expected %0b, got %0b", want.active, voice_active);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_FORMAT:    fmt        = fmt_t'(cfg_data[1:0]);
					CFG_START:     start_addr = cfg_data[ADDR_W-1:0];
					CFG_END:       end_addr   = cfg_data[ADDR_W-1:0];
					CFG_LOOP_ADDR: loop_addr  = cfg_data[ADDR_W-1:0];
					CFG_LOOP_EN:   loop_en    = cfg_data[0];
					CFG_LOOP_CTX:  loop_ctx   = cfg_data;
					CFG_INIT_CTX:  init_ctx   = cfg_data;
					default:       mem_size   = cfg_data[SIZE_W-1:0];
				endcase
			end
			if (in_valid && !in_stall)
				due_words.push_back(voice_step(req_t'(req_type), write_index, write_data));
			busy       <= (due_words.size() != 0);
			fail_count <= mismatches;
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the voice sample fetch regression: clock, reset, word stimulus and verdict.
// Depends on dvsf_pkg, dsp_adpcm_voice_sample_fetch and dvsf_voice_checker.
module tb_top import dvsf_pkg::*; ();

	// Bytes 0..FILL_BYTES-1 of the store are loaded before the voice is first
	// started. Phases with a larger memory_size keep start, loop and end inside that
	// region, so a decode never touches a store byte that was never written.
	localparam int FILL_BYTES  = 64;
	localparam int ITEM_GOAL   = 550;
	localparam int CYCLE_LIMIT = 300000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           req_type = '0;
	logic [11:0]          write_index = '0;
	logic [15:0]          write_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SMP_W-1:0]     sample_out;
	logic                 ok;
	logic                 voice_active;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CTX_W-1:0]     cfg_data = '0;
	logic                 busy;
	int                   fail_count;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int words_sent     = 0;
	int cycles         = 0;

	dsp_adpcm_voice_sample_fetch dut (.*);
	dvsf_voice_checker chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the result channel at the current rate.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < sink_stall_pct);

	// Drop the run if it hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one input word after a random gap and hold it until taken. Valid stays
	// high afterwards so a back-to-back word never lowers and raises it in one step.
	task automatic send_word(input req_t r, input logic [11:0] idx, input logic [15:0] data);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= r;
		write_index <= idx;
		write_data  <= data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// Drain the block, then write all eight registers back to back.
	task automatic program_voice(input fmt_t f, input logic [31:0] s, input logic [31:0] e,
			input logic [31:0] l, input logic le, input logic [39:0] lc,
			input logic [39:0] ic, input logic [12:0] ms);
		logic [CTX_W-1:0] vals [8];
		vals[CFG_FORMAT]    = CTX_W'(f);
		vals[CFG_START]     = CTX_W'(s);
		vals[CFG_END]       = CTX_W'(e);
		vals[CFG_LOOP_ADDR] = CTX_W'(l);
		vals[CFG_LOOP_EN]   = CTX_W'(le);
		vals[CFG_LOOP_CTX]  = lc;
		vals[CFG_INIT_CTX]  = ic;
		vals[CFG_MEM_SIZE]  = CTX_W'(ms);
		in_valid <= 1'b0;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		for (int k = 0; k < 8; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_reg_t'(k);
			cfg_data  <= vals[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Start the voice, then ask for n samples.
	task automatic play(input int n);
		send_word(REQ_START, 12'($urandom), 16'($urandom));
		repeat (n)
			send_word(REQ_DECODE, 12'($urandom), 16'($urandom));
	endtask

	// Mostly a valid predictor (0..7) with any scale; sometimes a bad one.
	function automatic logic [39:0] rand_ctx();
		logic [7:0] p;
		p = ($urandom_range(99) < 85) ? {1'b0, 7'($urandom)} : 8'($urandom);
		return {p, 32'($urandom)};
	endfunction

	initial begin
		fmt_t        f;
		logic [31:0] s, e, l, span;
		logic [12:0] ms;
		logic        full;
		int          r, n, ph;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// decode on a voice that was never started, bad coefficient indexes, top store byte
		send_word(REQ_DECODE, 12'hFFF, 16'hFFFF);
		send_word(REQ_COEF, 12'd16, 16'h1234);
		send_word(REQ_COEF, 12'hFFF, 16'hFFFF);
		send_word(REQ_STORE, 12'hFFF, 16'hFFFF);

		// load the sample region; frame headers lean toward a usable predictor
		for (int i = 0; i < FILL_BYTES; i++)
			send_word(REQ_STORE, 12'(i), {8'($urandom),
				(i % 8 == 0 && $urandom_range(4) != 0) ? {1'b0, 7'($urandom)} : 8'($urandom)});
		for (int i = 0; i < COEF_COUNT; i++) begin
			r = $urandom_range(7);
			send_word(REQ_COEF, 12'(i), (r == 0) ? 16'h7FFF : (r == 1) ? 16'h8000 : 16'($urandom));
		end
		// header of the frame at nibble 80: predictor 15
		send_word(REQ_STORE, 12'd40, 16'h00F3);

		// through a frame header to the end address, loop back with the loop context
		program_voice(FMT_ADPCM, 30, 34, 30, 1'b1, {8'h7F, 32'h8000_7FFF},
			{8'h2B, 32'h7FFF_8000}, 13'(FILL_BYTES));
		play(5);
		// predictor above 7 from the initial context
		program_voice(FMT_ADPCM, 3, 20, 0, 1'b0, 40'h0, {8'h95, 32'h1234_5678},
			13'(FILL_BYTES));
		play(1);
		// bad nibble position
		program_voice(FMT_ADPCM, 17, 40, 0, 1'b1, 40'h0, 40'h0, 13'(FILL_BYTES));
		play(1);
		// header beyond the valid bytes
		program_voice(FMT_ADPCM, 32, 40, 0, 1'b1, 40'h0, 40'h0, 13'd2);
		play(1);
		// header read, data beyond the valid bytes
		program_voice(FMT_ADPCM, 32, 40, 0, 1'b1, 40'h0, 40'h0, 13'd17);
		play(1);
		// header read, its predictor above 7
		program_voice(FMT_ADPCM, 80, 100, 0, 1'b1, 40'h0, 40'h0, 13'(FILL_BYTES));
		play(1);
		// big-endian words, stop at the end, then decode on the stopped voice
		program_voice(FMT_PCM16, 30, 31, 0, 1'b0, 40'h0, rand_ctx(), 13'(FILL_BYTES));
		play(3);
		// bytes scaled by 256, loop restores context in every format
		program_voice(FMT_PCM8, 62, 63, 62, 1'b1, 40'hFF_FFFF_FFFF, 40'h0, 13'(FILL_BYTES));
		play(3);
		program_voice(FMT_NONE, 0, 10, 0, 1'b1, 40'h0, 40'h0, 13'(FILL_BYTES));
		play(1);
		// top of the address space, size register above the store
		program_voice(FMT_PCM8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			40'hFF_FFFF_FFFF, 40'h0, 13'h1FFF);
		play(1);

		// random phases, each under its own settings and idling mix
		for (ph = 0; words_sent < ITEM_GOAL; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
				default: begin src_idle_pct = 11; sink_stall_pct = 11; end
			endcase
			f = ($urandom_range(9) == 0) ? FMT_NONE : fmt_t'($urandom_range(2));
			span = (f == FMT_ADPCM) ? 2 * FILL_BYTES : (f == FMT_PCM16) ? FILL_BYTES / 2 : FILL_BYTES;
			full = ($urandom_range(99) < 30);
			if (full) begin
				// size reaches unwritten bytes: keep the play range inside the region
				r  = $urandom_range(2);
				ms = (r == 0) ? 13'd4096 : (r == 1) ? 13'h1FFF : 13'($urandom_range(FILL_BYTES + 1, 8191));
				if (f == FMT_ADPCM)
					e = $urandom_range(0, span / 16 - 1) * 16 + $urandom_range(2, 15);
				else
					e = $urandom_range(0, span - 1);
				s = $urandom_range(0, e);
				l = $urandom_range(0, e);
			end else begin
				r  = $urandom_range(9);
				ms = (r == 0) ? 13'd0 : (r < 4) ? 13'(FILL_BYTES) : 13'($urandom_range(1, FILL_BYTES));
				s  = ($urandom_range(19) == 0) ? 32'hFFFF_FFFF - $urandom_range(3)
					: $urandom_range(0, span + 8);
				e  = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(s, span + 8);
				l  = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, span + 8);
			end
			program_voice(f, s, e, l, 1'($urandom), rand_ctx(), rand_ctx(), ms);
			// free phases sometimes carry on from wherever the last one left the voice
			if (full || $urandom_range(99) >= 30)
				send_word(REQ_START, 12'($urandom), 16'($urandom));
			n = $urandom_range(10, 30);
			repeat (n) begin
				r = $urandom_range(99);
				if (r < 65)
					send_word(REQ_DECODE, 12'($urandom), 16'($urandom));
				else if (r < 73)
					send_word(REQ_START, 12'($urandom), 16'($urandom));
				else if (r < 88)
					send_word(REQ_STORE, $urandom_range(1) ? 12'($urandom_range(FILL_BYTES - 1))
						: 12'($urandom), 16'($urandom));
				else
					send_word(REQ_COEF, ($urandom_range(4) == 0) ? 12'($urandom)
						: 12'($urandom_range(COEF_COUNT - 1)), 16'($urandom));
			end
		end

		// drain, let the pipe settle, then judge
		in_valid <= 1'b0;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
